@@ sv/quad_separating_axis_test_defines.svh @@
// Assertion macros shared by the collision test block.
`ifndef QUAD_SEPARATING_AXIS_TEST_DEFINES_SVH
`define QUAD_SEPARATING_AXIS_TEST_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define QSAT_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Sequence or condition that must be followed by a consequence in the next cycle.
`define QSAT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/qsat_pkg.sv @@
package qsat_pkg;

	// Packed corner word: signed x in the upper half, signed y in the lower half.
	localparam int CORNER_W = 32;
	localparam int HALF_W = 16;

	// Unsigned reach radius sum.
	localparam int REACH_W = 17;

	// Quad geometry: four corners per quad, one normal per edge of both quads.
	localparam int NUM_CORNERS = 4;
	localparam int NUM_POINTS = 2 * NUM_CORNERS;
	localparam int NUM_AXES = 2 * NUM_CORNERS;

endpackage

@@ sv/qsat_pair_if.sv @@
interface qsat_pair_if
	import qsat_pkg::*;
();

	logic                valid;
	logic                ready;
	logic [CORNER_W-1:0] own_corner_0;
	logic [CORNER_W-1:0] own_corner_1;
	logic [CORNER_W-1:0] own_corner_2;
	logic [CORNER_W-1:0] own_corner_3;
	logic [CORNER_W-1:0] own_center;
	logic [CORNER_W-1:0] other_corner_0;
	logic [CORNER_W-1:0] other_corner_1;
	logic [CORNER_W-1:0] other_corner_2;
	logic [CORNER_W-1:0] other_corner_3;
	logic [REACH_W-1:0]  reach_sum;
	logic                other_is_trigger;

	modport source (
		output valid, own_corner_0, own_corner_1, own_corner_2, own_corner_3, own_center,
		output other_corner_0, other_corner_1, other_corner_2, other_corner_3,
		output reach_sum, other_is_trigger,
		input  ready
	);

	modport sink (
		input  valid, own_corner_0, own_corner_1, own_corner_2, own_corner_3, own_center,
		input  other_corner_0, other_corner_1, other_corner_2, other_corner_3,
		input  reach_sum, other_is_trigger,
		output ready
	);

endinterface

@@ sv/qsat_result_if.sv @@
interface qsat_result_if;

	logic valid;
	logic ready;
	logic collides;
	logic trigger_hit;
	logic far_reject;

	modport source (
		output valid, collides, trigger_hit, far_reject,
		input  ready
	);

	modport sink (
		input  valid, collides, trigger_hit, far_reject,
		output ready
	);

endinterface

@@ sv/quad_separating_axis_test.sv @@
// An accepted pair word passes through the input, edge normal and projection registers in turn
// and then appears as a valid word in the result register.
// Throughput: one pair word per cycle; the four register stages (input, edge normals,
// projections, result) advance together whenever the result register is empty or taken.
// Reset clears only the stage valid bits; the payload registers are not reset.
// A stall on the result side holds every stage and deasserts ready on the pair side.
`include "quad_separating_axis_test_defines.svh"

module quad_separating_axis_test
	import qsat_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input logic          clk,
	input logic          arst_n,
	qsat_pair_if.sink    pair,
	qsat_result_if.source result
);

	// Used coordinate width and derived arithmetic widths.
	localparam int CW = (COORD_BITS < HALF_W) ? COORD_BITS : HALF_W;
	localparam int NW = CW + 1;
	localparam int PW = 2 * CW + 2;
	localparam int SW = CW + 3;
	localparam int QW = 2 * SW;
	localparam int R4W = REACH_W + 2;
	localparam int LIMW = 2 * R4W;
	localparam int LW = (QW > LIMW) ? QW : LIMW;

	// Pipeline control: all stages move together.
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;

	assign adv = !v_s4 || result.ready;
	assign pair.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pair.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: input register with the used coordinate bits of every corner.
	// Points 0 to 3 are this box, points 4 to 7 the other box.
	logic [CORNER_W-1:0] word_c [NUM_POINTS];

	assign word_c[0] = pair.own_corner_0;
	assign word_c[1] = pair.own_corner_1;
	assign word_c[2] = pair.own_corner_2;
	assign word_c[3] = pair.own_corner_3;
	assign word_c[4] = pair.other_corner_0;
	assign word_c[5] = pair.other_corner_1;
	assign word_c[6] = pair.other_corner_2;
	assign word_c[7] = pair.other_corner_3;

	logic signed [CW-1:0] px_s1 [NUM_POINTS];
	logic signed [CW-1:0] py_s1 [NUM_POINTS];
	logic signed [CW-1:0] cx_s1, cy_s1;
	logic [REACH_W-1:0]   reach_s1;
	logic                 trig_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NUM_POINTS; i++) begin
				px_s1[i] <= word_c[i][HALF_W +: CW];
				py_s1[i] <= word_c[i][0 +: CW];
			end
			cx_s1    <= pair.own_center[HALF_W +: CW];
			cy_s1    <= pair.own_center[0 +: CW];
			reach_s1 <= pair.reach_sum;
			trig_s1  <= pair.other_is_trigger;
		end
	end

	// Stage 2 logic: edge normals of both quads, corners taken in ring order.
	logic signed [NW-1:0] nx_c [NUM_AXES];
	logic signed [NW-1:0] ny_c [NUM_AXES];

	for (genvar k = 0; k < NUM_AXES; k++) begin : g_normal
		localparam int Base = (k / NUM_CORNERS) * NUM_CORNERS;
		localparam int Ia = Base + (k % NUM_CORNERS);
		localparam int Ib = Base + ((k + 1) % NUM_CORNERS);

		assign nx_c[k] = {py_s1[Ia][CW-1], py_s1[Ia]} - {py_s1[Ib][CW-1], py_s1[Ib]};
		assign ny_c[k] = {px_s1[Ib][CW-1], px_s1[Ib]} - {px_s1[Ia][CW-1], px_s1[Ia]};
	end

	// Stage 2 logic: four times the center minus the other box's corner sum.
	logic signed [SW-1:0] sx_c, sy_c, dx_c, dy_c;

	assign sx_c = {{3{px_s1[4][CW-1]}}, px_s1[4]} + {{3{px_s1[5][CW-1]}}, px_s1[5]}
		+ {{3{px_s1[6][CW-1]}}, px_s1[6]} + {{3{px_s1[7][CW-1]}}, px_s1[7]};
	assign sy_c = {{3{py_s1[4][CW-1]}}, py_s1[4]} + {{3{py_s1[5][CW-1]}}, py_s1[5]}
		+ {{3{py_s1[6][CW-1]}}, py_s1[6]} + {{3{py_s1[7][CW-1]}}, py_s1[7]};
	assign dx_c = {cx_s1[CW-1], cx_s1, 2'b00} - sx_c;
	assign dy_c = {cy_s1[CW-1], cy_s1, 2'b00} - sy_c;

	logic signed [NW-1:0] nx_s2 [NUM_AXES];
	logic signed [NW-1:0] ny_s2 [NUM_AXES];
	logic signed [CW-1:0] px_s2 [NUM_POINTS];
	logic signed [CW-1:0] py_s2 [NUM_POINTS];
	logic signed [SW-1:0] dx_s2, dy_s2;
	logic [R4W-1:0]       r4_s2;
	logic                 trig_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s2   <= nx_c;
			ny_s2   <= ny_c;
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			dx_s2   <= dx_c;
			dy_s2   <= dy_c;
			r4_s2   <= {reach_s1, 2'b00};
			trig_s2 <= trig_s1;
		end
	end

	// Stage 3 logic: project every corner onto every normal, and form both squares.
	logic signed [PW-1:0] dot_c [NUM_AXES][NUM_POINTS];

	for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
		for (genvar p = 0; p < NUM_POINTS; p++) begin : g_point
			assign dot_c[k][p] = px_s2[p] * nx_s2[k] + py_s2[p] * ny_s2[k];
		end
	end

	logic signed [QW-1:0] sqx_c, sqy_c;
	logic [QW-1:0]        dist2_c;
	logic [LIMW-1:0]      lim2_c;

	assign sqx_c   = dx_s2 * dx_s2;
	assign sqy_c   = dy_s2 * dy_s2;
	assign dist2_c = $unsigned(sqx_c) + $unsigned(sqy_c);
	assign lim2_c  = r4_s2 * r4_s2;

	logic signed [PW-1:0] dot_s3 [NUM_AXES][NUM_POINTS];
	logic [QW-1:0]        dist2_s3;
	logic [LIMW-1:0]      lim2_s3;
	logic                 trig_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			dot_s3   <= dot_c;
			dist2_s3 <= dist2_c;
			lim2_s3  <= lim2_c;
			trig_s3  <= trig_s2;
		end
	end

	// Stage 4 logic: projection intervals per axis; touching intervals count as a gap.
	logic [NUM_AXES-1:0] gap_c;

	always_comb begin
		logic signed [PW-1:0] mna, mxa, mnb, mxb;
		for (int k = 0; k < NUM_AXES; k++) begin
			mna = dot_s3[k][0];
			mxa = dot_s3[k][0];
			mnb = dot_s3[k][NUM_CORNERS];
			mxb = dot_s3[k][NUM_CORNERS];
			for (int p = 1; p < NUM_CORNERS; p++) begin
				if (dot_s3[k][p] < mna) mna = dot_s3[k][p];
				if (dot_s3[k][p] > mxa) mxa = dot_s3[k][p];
				if (dot_s3[k][NUM_CORNERS + p] < mnb) mnb = dot_s3[k][NUM_CORNERS + p];
				if (dot_s3[k][NUM_CORNERS + p] > mxb) mxb = dot_s3[k][NUM_CORNERS + p];
			end
			gap_c[k] = (mna >= mxb) || (mnb >= mxa);
		end
	end

	// Coarse distance check overrides the axis test.
	logic far_c, col_c;

	assign far_c = LW'(dist2_s3) > LW'(lim2_s3);
	assign col_c = !far_c && !(|gap_c);

	// Result register.
	logic col_s4, hit_s4, far_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s4 <= col_c;
			hit_s4 <= col_c && trig_s3;
			far_s4 <= far_c;
		end
	end

	assign result.valid       = v_s4;
	assign result.collides    = col_s4;
	assign result.trigger_hit = hit_s4;
	assign result.far_reject  = far_s4;

	// A coarse reject never collides, and a trigger hit always collides.
	`QSAT_ASSERT_ALWAYS(a_flags_consistent, !v_s4 || ((!far_s4 || !col_s4) && (!hit_s4 || col_s4)), "inconsistent result flags")

	// An accepted pair reaches the result register once the pipeline has advanced it through the remaining stages.
	`QSAT_ASSERT_NEXT(a_latency, (pair.valid && pair.ready) ##1 adv ##1 adv ##1 adv, result.valid, "accepted pair did not reach the result register")

	// An empty third stage cannot produce a result word.
	`QSAT_ASSERT_NEXT(a_no_phantom, adv && !v_s3, !result.valid, "result word appeared from an empty stage")

endmodule

@@ sim/testbench.sv @@
module testbench
	import qsat_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS = 16;
	localparam int RANDOM_PAIRS = 2000;
	localparam int DRAIN_CYCLES = 12;
	localparam longint CYCLE_LIMIT = 400000;

	typedef logic [CORNER_W-1:0] quad_words_t [NUM_CORNERS];

	typedef struct {
		quad_words_t             own;
		logic [CORNER_W-1:0]     center;
		quad_words_t             other;
		logic [REACH_W-1:0]      reach;
		logic                    trig;
	} pair_word_t;

	typedef struct packed {
		logic collides;
		logic trigger_hit;
		logic far_reject;
	} verdict_t;

	typedef struct {
		longint x [NUM_CORNERS];
		longint y [NUM_CORNERS];
	} quad_pts_t;

	logic clk;
	logic arst_n;

	qsat_pair_if   pair();
	qsat_result_if result();

	quad_separating_axis_test #(.COORD_BITS(COORD_BITS)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair),
		.result (result)
	);

	verdict_t expected_verdicts [$];
	int unsigned mismatches = 0;
	longint unsigned cycle_count = 0;
	bit gaps_on = 1'b0;
	bit stalls_on = 1'b0;
	int burst_left = 0;

	// Free-running clock, 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------
	// Collision predictor
	// ---------------------------------------------------------------

	// Sign-extend the used low bits of one half of a corner word.
	function automatic longint coord_of(input logic [HALF_W-1:0] half);
		int cb;
		longint v;
		cb = (COORD_BITS < HALF_W) ? COORD_BITS : HALF_W;
		v = 0;
		for (int b = 0; b < cb; b++)
			if (half[b]) v = v + (longint'(1) << b);
		if (half[cb-1]) v = v - (longint'(1) << cb);
		return v;
	endfunction

	function automatic quad_pts_t corner_points(input quad_words_t w);
		quad_pts_t q;
		for (int i = 0; i < NUM_CORNERS; i++) begin
			q.x[i] = coord_of(w[i][CORNER_W-1:HALF_W]);
			q.y[i] = coord_of(w[i][HALF_W-1:0]);
		end
		return q;
	endfunction

	// Smallest and largest dot product of the quad's corners with (nx, ny).
	function automatic void project_span(input quad_pts_t q, input longint nx, input longint ny,
			output longint lo, output longint hi);
		longint d;
		lo = q.x[0] * nx + q.y[0] * ny;
		hi = lo;
		for (int i = 1; i < NUM_CORNERS; i++) begin
			d = q.x[i] * nx + q.y[i] * ny;
			if (d < lo) lo = d;
			if (d > hi) hi = d;
		end
	endfunction

	// True when one edge normal of quad e has a gap between e and f. Touching counts as a gap.
	function automatic bit edge_normal_separates(input quad_pts_t e, input quad_pts_t f);
		longint nx, ny, lo_e, hi_e, lo_f, hi_f;
		int j;
		for (int i = 0; i < NUM_CORNERS; i++) begin
			j = (i + 1) % NUM_CORNERS;
			nx = -(e.y[j] - e.y[i]);
			ny = e.x[j] - e.x[i];
			project_span(e, nx, ny, lo_e, hi_e);
			project_span(f, nx, ny, lo_f, hi_f);
			if (lo_e >= hi_f || lo_f >= hi_e) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic verdict_t predict_verdict(input pair_word_t p);
		quad_pts_t own_q, oth_q;
		longint dx, dy, r4;
		verdict_t v;
		own_q = corner_points(p.own);
		oth_q = corner_points(p.other);
		dx = 4 * coord_of(p.center[CORNER_W-1:HALF_W]);
		dy = 4 * coord_of(p.center[HALF_W-1:0]);
		for (int i = 0; i < NUM_CORNERS; i++) begin
			dx = dx - oth_q.x[i];
			dy = dy - oth_q.y[i];
		end
		r4 = 4 * longint'(p.reach);
		v = '0;
		// Coarse reject compares squared distances scaled by four, so no division is needed.
		v.far_reject = (dx * dx + dy * dy) > (r4 * r4);
		if (!v.far_reject)
			v.collides = !edge_normal_separates(own_q, oth_q) &&
				!edge_normal_separates(oth_q, own_q);
		v.trigger_hit = v.collides && p.trig;
		return v;
	endfunction

	// ---------------------------------------------------------------
	// Word builders
	// ---------------------------------------------------------------

	function automatic logic [CORNER_W-1:0] pt(input int x, input int y);
		return {HALF_W'(x), HALF_W'(y)};
	endfunction

	function automatic quad_words_t rect(input int x0, input int y0, input int x1, input int y1);
		quad_words_t q;
		q[0] = pt(x0, y0);
		q[1] = pt(x1, y0);
		q[2] = pt(x1, y1);
		q[3] = pt(x0, y1);
		return q;
	endfunction

	function automatic pair_word_t make_pair(input quad_words_t own_q,
			input logic [CORNER_W-1:0] ctr, input quad_words_t oth_q,
			input logic [REACH_W-1:0] reach, input logic trig);
		pair_word_t p;
		p.own = own_q;
		p.center = ctr;
		p.other = oth_q;
		p.reach = reach;
		p.trig = trig;
		return p;
	endfunction

	// A rotated box around (cx, cy); sometimes jittered or with crossed corners.
	function automatic quad_words_t random_box(input int cx, input int cy);
		quad_words_t q;
		logic [CORNER_W-1:0] t;
		int ux, uy, vx, vy, k;
		int xs [NUM_CORNERS];
		int ys [NUM_CORNERS];
		ux = int'($urandom_range(0, 800)) - 400;
		uy = int'($urandom_range(0, 800)) - 400;
		k = int'($urandom_range(0, 16));
		vx = -uy * k / 8;
		vy = ux * k / 8;
		xs = '{cx + ux + vx, cx - ux + vx, cx - ux - vx, cx + ux - vx};
		ys = '{cy + uy + vy, cy - uy + vy, cy - uy - vy, cy + uy - vy};
		for (int i = 0; i < NUM_CORNERS; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				xs[i] = xs[i] + int'($urandom_range(0, 40)) - 20;
				ys[i] = ys[i] + int'($urandom_range(0, 40)) - 20;
			end
			q[i] = pt(xs[i], ys[i]);
		end
		if ($urandom_range(0, 9) == 0) begin
			t = q[1];
			q[1] = q[2];
			q[2] = t;
		end
		return q;
	endfunction

	// Two nearby boxes with a reach sum that mostly lets the pair past the coarse check.
	function automatic pair_word_t shaped_pair();
		int cx, cy, ox, oy;
		logic [REACH_W-1:0] reach;
		cx = int'($urandom_range(0, 60000)) - 30000;
		cy = int'($urandom_range(0, 60000)) - 30000;
		ox = cx + int'($urandom_range(0, 2400)) - 1200;
		oy = cy + int'($urandom_range(0, 2400)) - 1200;
		case ($urandom_range(0, 9))
			7, 8: begin
				reach = REACH_W'($urandom_range(0, 2600));
			end
			9: begin
				reach = REACH_W'($urandom_range(0, (1 << REACH_W) - 1));
			end
			default: begin
				reach = REACH_W'($urandom_range(2600, 6000));
			end
		endcase
		return make_pair(random_box(cx, cy),
			pt(cx + int'($urandom_range(0, 20)) - 10, cy + int'($urandom_range(0, 20)) - 10),
			random_box(ox, oy), reach, 1'($urandom_range(0, 1)));
	endfunction

	function automatic pair_word_t noise_pair();
		pair_word_t p;
		for (int i = 0; i < NUM_CORNERS; i++) begin
			p.own[i] = $urandom;
			p.other[i] = $urandom;
		end
		p.center = $urandom;
		p.reach = REACH_W'($urandom_range(0, (1 << REACH_W) - 1));
		p.trig = 1'($urandom_range(0, 1));
		return p;
	endfunction

	// ---------------------------------------------------------------
	// Pair side driver
	// ---------------------------------------------------------------

	// Present one pair word and wait until it is taken. Valid stays high for a following word.
	task automatic send_pair(input pair_word_t p);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = int'($urandom_range(1, 6));
			pair.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = int'($urandom_range(1, 12));
		end
		if (burst_left > 0) burst_left--;
		pair.own_corner_0     <= p.own[0];
		pair.own_corner_1     <= p.own[1];
		pair.own_corner_2     <= p.own[2];
		pair.own_corner_3     <= p.own[3];
		pair.own_center       <= p.center;
		pair.other_corner_0   <= p.other[0];
		pair.other_corner_1   <= p.other[1];
		pair.other_corner_2   <= p.other[2];
		pair.other_corner_3   <= p.other[3];
		pair.reach_sum        <= p.reach;
		pair.other_is_trigger <= p.trig;
		pair.valid            <= 1'b1;
		do @(posedge clk); while (pair.ready !== 1'b1);
		expected_verdicts.insert(expected_verdicts.size(), predict_verdict(p));
	endtask

	// Stop sending and wait until every outstanding verdict has come back.
	task automatic settle_pairs();
		pair.valid <= 1'b0;
		do @(posedge clk); while (expected_verdicts.size() != 0);
	endtask

	// ---------------------------------------------------------------
	// Result side: stall pattern and checker
	// ---------------------------------------------------------------

	initial begin
		logic [15:0] hold_pattern;
		hold_pattern = 16'b1011_0011_1000_1101;
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			hold_pattern = {hold_pattern[0], hold_pattern[15:1]};
			result.ready <= stalls_on ? hold_pattern[0] : 1'b1;
		end
	end

	// Compare each result word with the oldest predicted verdict.
	always @(posedge clk) begin
		verdict_t got, want;
		if (arst_n === 1'b1 && result.valid === 1'b1 && result.ready === 1'b1) begin
			got = {result.collides, result.trigger_hit, result.far_reject};
			if (expected_verdicts.size() == 0) begin
				mismatches++;
				$display({"%0t: result word with no pair pending: expected none,",
					" actual collides=%b trigger_hit=%b far_reject=%b"},
					$time, got.collides, got.trigger_hit, got.far_reject);
			end else begin
				want = expected_verdicts.pop_front();
				if (got !== want) begin
					mismatches++;
					$display({"%0t: verdict mismatch: expected collides=%b trigger_hit=%b far_reject=%b,",
						" actual collides=%b trigger_hit=%b far_reject=%b"}, $time,
						want.collides, want.trigger_hit, want.far_reject,
						got.collides, got.trigger_hit, got.far_reject);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Extreme coordinates and reach sums, including all-zero and all-one words.
	task automatic test_extreme_words();
		quad_words_t whole;
		whole = rect(-32768, -32768, 32767, 32767);
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		send_pair(make_pair('{default: '0}, '0, '{default: '0}, '0, 1'b0));
		send_pair(make_pair('{default: '1}, '1, '{default: '1}, '1, 1'b1));
		send_pair(make_pair('{default: pt(32767, 32767)}, pt(-32768, -32768),
			'{default: pt(-32768, -32768)}, '1, 1'b1));
		send_pair(make_pair(whole, pt(0, 0), rect(-100, -100, 100, 100), '1, 1'b1));
		send_pair(make_pair(whole, pt(0, 0), rect(-100, -100, 100, 100), '0, 1'b0));
		send_pair(make_pair(whole, pt(-32768, -32768), rect(32000, 32000, 32767, 32767), '0, 1'b1));
		send_pair(make_pair(whole, pt(0, 0), whole, '1, 1'b0));
		settle_pairs();
	endtask

	// Coarse distance check exactly at and just past the reach sum.
	task automatic test_coarse_check();
		quad_words_t own_q, oth_q;
		own_q = rect(-20, -20, 20, 20);
		oth_q = rect(-10, -10, 10, 10);
		gaps_on = 1'b1;
		stalls_on = 1'b0;
		send_pair(make_pair(own_q, pt(100, 0), oth_q, 100, 1'b0));
		send_pair(make_pair(own_q, pt(100, 0), oth_q, 99, 1'b0));
		send_pair(make_pair(own_q, pt(30, 40), oth_q, 50, 1'b1));
		send_pair(make_pair(own_q, pt(30, 40), oth_q, 49, 1'b1));
		send_pair(make_pair(own_q, pt(-30, -40), oth_q, 50, 1'b0));
		settle_pairs();
	endtask

	// Shared edges and corners separate; overlap and containment collide.
	task automatic test_touching_boxes();
		quad_words_t own_q;
		own_q = rect(0, 0, 10, 10);
		gaps_on = 1'b0;
		stalls_on = 1'b1;
		send_pair(make_pair(own_q, pt(5, 5), rect(10, 0, 20, 10), 1000, 1'b0));
		send_pair(make_pair(own_q, pt(5, 5), rect(9, 0, 19, 10), 1000, 1'b0));
		send_pair(make_pair(own_q, pt(5, 5), rect(10, 10, 20, 20), 1000, 1'b0));
		send_pair(make_pair(own_q, pt(5, 5), rect(2, 2, 5, 5), 1000, 1'b0));
		send_pair(make_pair(own_q, pt(5, 5), rect(0, 10, 10, 20), 1000, 1'b0));
		settle_pairs();
	endtask

	// Zero-length edges give a zero normal, which always counts as a gap.
	task automatic test_degenerate_edges();
		quad_words_t box;
		box = rect(0, 0, 10, 10);
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		send_pair(make_pair('{pt(0, 0), pt(0, 0), pt(10, 10), pt(0, 10)}, pt(5, 5), box,
			1000, 1'b1));
		send_pair(make_pair('{default: pt(5, 5)}, pt(5, 5), box, 1000, 1'b1));
		send_pair(make_pair(box, pt(5, 5), '{default: pt(5, 5)}, 1000, 1'b1));
		settle_pairs();
	endtask

	// The trigger flag shows up only on a real collision.
	task automatic test_trigger_flag();
		quad_words_t own_q;
		own_q = rect(0, 0, 10, 10);
		send_pair(make_pair(own_q, pt(5, 5), rect(5, 5, 15, 15), 1000, 1'b1));
		send_pair(make_pair(own_q, pt(5, 5), rect(20, 20, 30, 30), 1000, 1'b1));
		send_pair(make_pair(own_q, pt(5, 5), rect(5, 5, 15, 15), 0, 1'b1));
		settle_pairs();
	endtask

	// Corners are used in the order given: a crossed quad and a reversed winding.
	task automatic test_corner_order();
		send_pair(make_pair('{pt(0, 0), pt(10, 10), pt(10, 0), pt(0, 10)}, pt(5, 5),
			rect(2, 2, 8, 8), 1000, 1'b0));
		send_pair(make_pair(rect(10, 10, 0, 0), pt(5, 5), rect(2, 2, 8, 8), 1000, 1'b1));
		settle_pairs();
	endtask

	// Mostly nearby box pairs with random shapes, the rest random words.
	task automatic test_random_pairs();
		pair_word_t p;
		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			if (n % 250 == 0) begin
				gaps_on = ((n / 250) % 2) == 1;
				stalls_on = ((n / 500) % 2) == 1;
			end
			if (n == RANDOM_PAIRS / 2) settle_pairs();
			if ($urandom_range(0, 3) == 0)
				p = noise_pair();
			else
				p = shaped_pair();
			send_pair(p);
		end
		settle_pairs();
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		pair.valid            <= 1'b0;
		pair.own_corner_0     <= '0;
		pair.own_corner_1     <= '0;
		pair.own_corner_2     <= '0;
		pair.own_corner_3     <= '0;
		pair.own_center       <= '0;
		pair.other_corner_0   <= '0;
		pair.other_corner_1   <= '0;
		pair.other_corner_2   <= '0;
		pair.other_corner_3   <= '0;
		pair.reach_sum        <= '0;
		pair.other_is_trigger <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extreme_words();
		test_coarse_check();
		test_touching_boxes();
		test_degenerate_edges();
		test_trigger_flag();
		test_corner_order();
		test_random_pairs();

		// Let the pipeline run empty so that a stray result word would still be seen.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_verdicts.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/qsat_pkg.sv
sv/qsat_pair_if.sv
sv/qsat_result_if.sv
sv/quad_separating_axis_test.sv
sim/testbench.sv
